// ----- rtl/core/scsm_pkg.sv -----
// Package for the script comment and string masker.
// Holds character codes, the default bracket level limit, the result slot type and the masking function.
// No dependencies.
`default_nettype none

package scsm_pkg;

   // default limit on '=' signs in a long bracket
   localparam int SCSM_MAX_LEVEL_DEFAULT = 8;

   // character codes
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_LBRACK = 8'h5B;
   localparam logic [7:0] CHR_EQUALS = 8'h3D;
   localparam logic [7:0] CHR_RBRACK = 8'h5D;
   localparam logic [7:0] CHR_DASH   = 8'h2D;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_SPACE  = 8'h20;

   // one result byte of a run: present, character, masked
   typedef struct packed {
      logic       vld;
      logic [7:0] chr;
      logic       msk;
   } slot_type;

   // apply masking: a masked byte becomes a space unless it is CR or LF
   function automatic slot_type mask_slot(input slot_type s);
      slot_type r;
      r = s;
      if (s.msk && (s.chr != CHR_CR) && (s.chr != CHR_LF)) begin
         r.chr = CHR_SPACE;
         r.msk = 1'b1;
      end else begin
         r.msk = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/script_comment_string_masker.sv -----
// Script comment and string masker: top level, single module.
// Depends on scsm_pkg for character codes, the slot type and the masking function.
//
// Usage:
//   The request channel (req_valid, req_stall, req_in_byte, req_end_of_text)
//   carries one byte of script text per request; req_end_of_text marks the
//   last byte of a text. The response channel (rsp_valid, rsp_stall, rsp_*)
//   delivers the bytes back, one per cycle while rsp_stall is low, with
//   comment and string contents turned into spaces. A request yields zero to
//   MAX_LEVEL+2 responses; rsp_run_last flags the last response of a request
//   and rsp_text_done the last response of a text.
//   A request passes through the input register, then the run register,
//   before its responses appear on the response channel.
//   Throughput: one request per cycle while each request yields at most one
//   response and rsp_stall is low; a request yielding more responses holds the
//   run register until its last response is taken.
//   Reset (synchronous, active high) returns the scanner to code mode and
//   empties both registers. While the receiver stalls, the current response
//   holds and requests back up through req_stall once the input register fills.
`default_nettype none

module script_comment_string_masker
   import scsm_pkg::*;
#(
   parameter int MAX_LEVEL = SCSM_MAX_LEVEL_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_was_masked,
   output logic            rsp_run_last,
   output logic            rsp_text_done,
   output logic            rsp_level_overflow
);

   localparam int LVL_W = $clog2(MAX_LEVEL + 1);
   localparam int CNT_W = $clog2(MAX_LEVEL + 3);

   // scanner modes
   localparam logic [3:0] MODE_NORMAL = 4'd0;
   localparam logic [3:0] MODE_DASH   = 4'd1;
   localparam logic [3:0] MODE_OPEN   = 4'd2;
   localparam logic [3:0] MODE_CSTART = 4'd3;
   localparam logic [3:0] MODE_COPEN  = 4'd4;
   localparam logic [3:0] MODE_LINE   = 4'd5;
   localparam logic [3:0] MODE_LONG   = 4'd6;
   localparam logic [3:0] MODE_QUOTE  = 4'd7;
   localparam logic [3:0] MODE_QESC   = 4'd8;

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   // scanner state
   logic [3:0]       mode_ff, mode_in;
   logic             qdbl_ff, qdbl_in;
   logic [LVL_W-1:0] held_ff, held_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             armed_ff, armed_in;
   logic [LVL_W-1:0] ceq_ff, ceq_in;

   // run register: lead byte, '=' repeat, scanned byte, tail byte
   logic             rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff;
   slot_type         lead_ff, s1_ff, s2_ff;
   logic [LVL_W-1:0] eq_n_ff;
   logic             eq_msk_ff;
   logic             ovf_ff;
   logic             eot_ff;

   // run computed for the request in the input register
   slot_type         lead, s1, s2, s1_fin, lead_fin;
   logic [LVL_W-1:0] eq_n;
   logic             eq_msk;
   logic             ovf;
   logic [CNT_W-1:0] cnt;

   // code-mode handling of the current byte
   logic [3:0] cb_mode;
   slot_type   cb_slot;
   logic       use_code;
   logic       use_line;

   logic [7:0] x;
   logic       in_accept, out_fire, out_last, rd_free, adv;
   logic [CNT_W-1:0] k_rel;

   assign x = in_byte_ff;

   // handshake and pipeline advance
   assign in_accept = req_valid && !req_stall;
   assign out_fire  = rd_vld_ff && !rsp_stall;
   assign out_last  = (pos_ff == (cnt_ff - CNT_W'(1)));
   assign rd_free   = !rd_vld_ff || (out_fire && out_last);
   assign adv       = in_vld_ff && rd_free;
   assign req_stall = in_vld_ff && !rd_free;

   // classify a byte seen in code
   always_comb begin
      cb_mode = MODE_NORMAL;
      cb_slot = '{vld: 1'b1, chr: x, msk: 1'b0};
      if (x == CHR_DASH) begin
         cb_mode     = MODE_DASH;
         cb_slot.vld = 1'b0;
      end else if ((x == CHR_SQUOTE) || (x == CHR_DQUOTE)) begin
         cb_mode     = MODE_QUOTE;
         cb_slot.msk = 1'b1;
      end else if (x == CHR_LBRACK) begin
         cb_mode     = MODE_OPEN;
         cb_slot.vld = 1'b0;
      end
   end

   // next state and the run of results for one request
   always_comb begin
      mode_in  = mode_ff;
      qdbl_in  = qdbl_ff;
      held_in  = held_ff;
      lvl_in   = lvl_ff;
      armed_in = armed_ff;
      ceq_in   = ceq_ff;
      lead     = '{vld: 1'b0, chr: CHR_LBRACK, msk: 1'b0};
      s1       = '{vld: 1'b0, chr: x, msk: 1'b0};
      s2       = '{vld: 1'b0, chr: CHR_DASH, msk: 1'b0};
      eq_n     = '0;
      eq_msk   = 1'b0;
      ovf      = 1'b0;
      use_code = 1'b0;
      use_line = 1'b0;

      unique case (mode_ff)
         MODE_DASH: begin
            if (x == CHR_DASH) begin
               lead    = '{vld: 1'b1, chr: CHR_DASH, msk: 1'b1};
               s1      = '{vld: 1'b1, chr: CHR_DASH, msk: 1'b1};
               mode_in = MODE_CSTART;
            end else begin
               lead     = '{vld: 1'b1, chr: CHR_DASH, msk: 1'b0};
               use_code = 1'b1;
            end
         end
         MODE_OPEN: begin
            if (x == CHR_EQUALS) begin
               if (held_ff < LVL_W'(MAX_LEVEL)) begin
                  held_in = held_ff + LVL_W'(1);
               end else begin
                  // level overflow: release everything unmasked
                  lead    = '{vld: 1'b1, chr: CHR_LBRACK, msk: 1'b0};
                  eq_n    = held_ff;
                  s1      = '{vld: 1'b1, chr: CHR_EQUALS, msk: 1'b0};
                  ovf     = 1'b1;
                  held_in = '0;
                  mode_in = MODE_NORMAL;
               end
            end else if (x == CHR_LBRACK) begin
               // long string opens
               lead     = '{vld: 1'b1, chr: CHR_LBRACK, msk: 1'b1};
               eq_n     = held_ff;
               eq_msk   = 1'b1;
               s1       = '{vld: 1'b1, chr: CHR_LBRACK, msk: 1'b1};
               lvl_in   = held_ff;
               armed_in = 1'b0;
               ceq_in   = '0;
               held_in  = '0;
               mode_in  = MODE_LONG;
            end else begin
               // failed open: release, then treat byte as code
               lead     = '{vld: 1'b1, chr: CHR_LBRACK, msk: 1'b0};
               eq_n     = held_ff;
               held_in  = '0;
               use_code = 1'b1;
            end
         end
         MODE_CSTART: begin
            if (x == CHR_LBRACK) begin
               s1      = '{vld: 1'b1, chr: x, msk: 1'b1};
               held_in = '0;
               mode_in = MODE_COPEN;
            end else begin
               use_line = 1'b1;
            end
         end
         MODE_COPEN: begin
            if (x == CHR_EQUALS) begin
               s1 = '{vld: 1'b1, chr: x, msk: 1'b1};
               if (held_ff < LVL_W'(MAX_LEVEL)) begin
                  held_in = held_ff + LVL_W'(1);
               end else begin
                  // too deep: fall back to a line comment
                  ovf     = 1'b1;
                  held_in = '0;
                  mode_in = MODE_LINE;
               end
            end else if (x == CHR_LBRACK) begin
               s1       = '{vld: 1'b1, chr: x, msk: 1'b1};
               lvl_in   = held_ff;
               armed_in = 1'b0;
               ceq_in   = '0;
               held_in  = '0;
               mode_in  = MODE_LONG;
            end else begin
               held_in  = '0;
               use_line = 1'b1;
            end
         end
         MODE_LINE: begin
            use_line = 1'b1;
         end
         MODE_LONG: begin
            s1 = '{vld: 1'b1, chr: x, msk: 1'b1};
            if (x == CHR_RBRACK) begin
               if (armed_ff && (ceq_ff == lvl_ff)) begin
                  mode_in  = MODE_NORMAL;
                  armed_in = 1'b0;
                  ceq_in   = '0;
                  lvl_in   = '0;
               end else begin
                  armed_in = 1'b1;
                  ceq_in   = '0;
               end
            end else if ((x == CHR_EQUALS) && armed_ff) begin
               if (ceq_ff < lvl_ff) begin
                  ceq_in = ceq_ff + LVL_W'(1);
               end else begin
                  armed_in = 1'b0;
               end
            end else begin
               armed_in = 1'b0;
            end
         end
         MODE_QUOTE: begin
            s1 = '{vld: 1'b1, chr: x, msk: 1'b1};
            if (x == CHR_BSLASH) begin
               mode_in = MODE_QESC;
            end else if (x == (qdbl_ff ? CHR_DQUOTE : CHR_SQUOTE)) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_QESC: begin
            s1      = '{vld: 1'b1, chr: x, msk: 1'b1};
            mode_in = MODE_QUOTE;
         end
         default: begin
            use_code = 1'b1;
         end
      endcase

      // byte handled as code
      if (use_code) begin
         mode_in = cb_mode;
         s1      = cb_slot;
         if (cb_mode == MODE_QUOTE) begin
            qdbl_in = (x == CHR_DQUOTE);
         end
         if (cb_mode == MODE_OPEN) begin
            held_in = '0;
         end
      end

      // byte handled inside a line comment
      if (use_line) begin
         if (x == CHR_LF) begin
            mode_in = MODE_NORMAL;
            s1      = '{vld: 1'b1, chr: x, msk: 1'b0};
         end else begin
            mode_in = MODE_LINE;
            s1      = '{vld: 1'b1, chr: x, msk: 1'b1};
         end
      end

      // end of text: release held bytes, drop back to reset state
      if (in_eot_ff) begin
         if (mode_in == MODE_DASH) begin
            s2 = '{vld: 1'b1, chr: CHR_DASH, msk: 1'b0};
         end else if (mode_in == MODE_OPEN) begin
            if (held_in == '0) begin
               s2 = '{vld: 1'b1, chr: CHR_LBRACK, msk: 1'b0};
            end else begin
               lead   = '{vld: 1'b1, chr: CHR_LBRACK, msk: 1'b0};
               eq_n   = held_in;
               eq_msk = 1'b0;
            end
         end
         mode_in  = MODE_NORMAL;
         qdbl_in  = 1'b0;
         held_in  = '0;
         lvl_in   = '0;
         armed_in = 1'b0;
         ceq_in   = '0;
      end
   end

   assign s1_fin   = mask_slot(s1);
   assign lead_fin = mask_slot(lead);
   assign cnt      = CNT_W'(lead.vld) + CNT_W'(eq_n) + CNT_W'(s1.vld) + CNT_W'(s2.vld);

   // control next values
   always_comb begin
      in_vld_in = in_vld_ff;
      if (in_accept) begin
         in_vld_in = 1'b1;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end

      rd_vld_in = rd_vld_ff;
      pos_in    = pos_ff;
      if (adv) begin
         rd_vld_in = (cnt != '0);
         pos_in    = '0;
      end else if (out_fire) begin
         if (out_last) begin
            rd_vld_in = 1'b0;
         end else begin
            pos_in = pos_ff + CNT_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         pos_ff    <= '0;
         mode_ff   <= MODE_NORMAL;
         qdbl_ff   <= 1'b0;
         held_ff   <= '0;
         lvl_ff    <= '0;
         armed_ff  <= 1'b0;
         ceq_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         rd_vld_ff <= rd_vld_in;
         pos_ff    <= pos_in;
         if (adv) begin
            mode_ff  <= mode_in;
            qdbl_ff  <= qdbl_in;
            held_ff  <= held_in;
            lvl_ff   <= lvl_in;
            armed_ff <= armed_in;
            ceq_ff   <= ceq_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_byte_ff <= req_in_byte;
         in_eot_ff  <= req_end_of_text;
      end
      if (adv) begin
         lead_ff   <= lead_fin;
         eq_n_ff   <= eq_n;
         eq_msk_ff <= eq_msk;
         s1_ff     <= s1_fin;
         s2_ff     <= s2;
         ovf_ff    <= ovf;
         eot_ff    <= in_eot_ff;
         cnt_ff    <= cnt;
      end
   end

   // select the byte at the current run position
   assign k_rel = pos_ff - CNT_W'(lead_ff.vld);

   always_comb begin
      if (lead_ff.vld && (pos_ff == '0)) begin
         rsp_out_byte   = lead_ff.chr;
         rsp_was_masked = lead_ff.msk;
      end else if (k_rel < CNT_W'(eq_n_ff)) begin
         rsp_out_byte   = eq_msk_ff ? CHR_SPACE : CHR_EQUALS;
         rsp_was_masked = eq_msk_ff;
      end else if (s1_ff.vld && (k_rel == CNT_W'(eq_n_ff))) begin
         rsp_out_byte   = s1_ff.chr;
         rsp_was_masked = s1_ff.msk;
      end else begin
         rsp_out_byte   = s2_ff.chr;
         rsp_was_masked = 1'b0;
      end
   end

   assign rsp_valid          = rd_vld_ff;
   assign rsp_run_last       = out_last;
   assign rsp_text_done      = out_last && eot_ff;
   assign rsp_level_overflow = ovf_ff;

`ifndef SYNTHESIS
   // run position stays inside the run
   a_pos_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (pos_ff < cnt_ff))
      else $error("run position beyond run length");

   // an empty run is never loaded
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (cnt_ff != '0))
      else $error("empty run loaded");

   // text end only on the last response of a run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_done) |-> rsp_run_last)
      else $error("text_done without run_last");

   // end of text leaves the scanner in code mode with nothing held
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && in_eot_ff) |=> ((mode_ff == MODE_NORMAL) && (held_ff == '0)))
      else $error("scanner state not cleared at end of text");

   // held '=' count never exceeds the level limit
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= LVL_W'(MAX_LEVEL))
      else $error("held '=' count beyond limit");
`endif

endmodule

`default_nettype wire
